// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the page range allocator RTL.
// Depends on nothing; the macros compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define BPRA_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bpra: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BPRA_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bpra: next-cycle check failed");

`else

`define BPRA_ASSERT_IMP(label, ck, rn, ante, cons)
`define BPRA_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

// ===== hw/rtl/bpra_pkg.sv =====
// Shared types, constants and bit-search functions for the page range allocator.
// Depends on nothing; imported by the top level, the controller and the datapath.
package bpra_pkg;

    // Default bitmap size and the fixed widths of the transfer fields.
    localparam int PAGES_DEFAULT = 512;
    localparam int COUNT_IN_W    = 10;
    localparam int START_W       = 9;
    localparam int USED_W        = 10;

    // The bitmap is held and scanned one word at a time.
    localparam int WORD_W  = 32;
    localparam int WORD_LG = 5;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NF_RD,
        ST_NF_CHK,
        ST_FF_RD,
        ST_FF_CHK,
        ST_MK_RD,
        ST_MK_WR,
        ST_DONE
    } state_t;

    // Datapath actions issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_START,
        ACT_READ,
        ACT_NF_TAKE,
        ACT_NF_NEXT,
        ACT_NF_WRAP,
        ACT_FF_SKIP,
        ACT_FF_NEXT,
        ACT_FF_TAKE,
        ACT_MARK,
        ACT_DELIVER
    } act_t;

    // Classification of an incoming request.
    typedef enum logic [1:0] {
        REQ_BAD,
        REQ_SINGLE,
        REQ_RUN
    } req_kind_t;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        req_kind_t kind;
        logic      last_word;
        logic      nf_found;
        logic      nf_wrapped;
        logic      ff_over;
        logic      ff_hit;
        logic      end_in_word;
        logic      out_free;
    } bpra_status_t;

    // Index of the lowest set bit of a word; zero when none is set.
    function automatic logic [WORD_LG-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [WORD_LG-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = WORD_LG'(i);
            end
        end
        return idx;
    endfunction

    // Index of the highest set bit of a word; zero when none is set.
    function automatic logic [WORD_LG-1:0] highest_set(input logic [WORD_W-1:0] v);
        logic [WORD_LG-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (v[i])
            begin
                idx = WORD_LG'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/bitmap_page_range_allocator_top.sv =====
// Bitmap page range allocator. Each request transfer asks for req_pages contiguous
// page slots out of PAGES; one result transfer follows per request. Requests are
// handled one at a time; the bitmap sits in a RAM of 32-bit words and every word
// visit is a registered read, then a check. A bad count skips the search.
// A single page is placed by next-fit from the rotating pointer, wrapping once to
// slot zero when it has to. A run is placed by first-fit: words are scanned, the
// search window skips past used slots, and the run is then marked word by word; a
// fragmented map adds its skips. Per-word valid bits clear the map at reset, so no
// clearing pass is needed. A finished result waits in an output register, and a new
// request is taken while it waits; that request's result then waits in the search
// until the register empties.
`include "assert_macros.svh"

module bitmap_page_range_allocator_top
    import bpra_pkg::*;
#(
    parameter int PAGES = PAGES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COUNT_IN_W-1:0] req_pages,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  granted,
    output logic [START_W-1:0]    start_index,
    output logic [USED_W-1:0]     pages_in_use
);

    act_t         act;
    bpra_status_t status;

    // Sequencer.
    bpra_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .act     (act)
    );

    // Bitmap, search logic and result register.
    bpra_dp #(
        .PAGES(PAGES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .act         (act),
        .status      (status),
        .req_pages   (req_pages),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .granted     (granted),
        .start_index (start_index),
        .pages_in_use(pages_in_use)
    );

    // A request transfer starts the datapath and closes the input until delivery.
    `BPRA_ASSERT_IMP(a_accept_starts, clk, rst_n, in_valid && !in_stall, act == ACT_START)
    `BPRA_ASSERT_NEXT(a_accept_stalls, clk, rst_n, in_valid && !in_stall, in_stall)
    // Delivery always fills the output register.
    `BPRA_ASSERT_NEXT(a_deliver_shows, clk, rst_n, act == ACT_DELIVER, out_valid)
    // A refused request reports start zero.
    `BPRA_ASSERT_IMP(a_refused_zero, clk, rst_n, out_valid && !granted, start_index == '0)

endmodule

// ===== hw/rtl/bpra_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the allocation bitmap.
module bpra_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bpra_ctrl.sv =====
// Sequencing state machine of the page range allocator.
// Depends on bpra_pkg; drives one datapath action per cycle from datapath status.
module bpra_ctrl
    import bpra_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  bpra_status_t status,
    output act_t         act
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and the action for this cycle.
    always_comb
    begin
        state_next = state_reg;
        act        = ACT_NONE;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    act = ACT_START;
                    unique case (status.kind)
                        REQ_SINGLE: state_next = ST_NF_RD;
                        REQ_RUN:    state_next = ST_FF_RD;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_NF_RD:
            begin
                act        = ACT_READ;
                state_next = ST_NF_CHK;
            end
            ST_NF_CHK:
            begin
                // Take the first free slot, else step on, wrapping once to slot zero.
                priority if (status.nf_found)
                begin
                    act        = ACT_NF_TAKE;
                    state_next = ST_DONE;
                end
                else if (status.last_word && status.nf_wrapped)
                begin
                    state_next = ST_DONE;
                end
                else if (status.last_word)
                begin
                    act        = ACT_NF_WRAP;
                    state_next = ST_NF_RD;
                end
                else
                begin
                    act        = ACT_NF_NEXT;
                    state_next = ST_NF_RD;
                end
            end
            ST_FF_RD:
            begin
                act        = ACT_READ;
                state_next = ST_FF_CHK;
            end
            ST_FF_CHK:
            begin
                // Skip past used slots in the window until the run fits or cannot.
                priority if (status.ff_over)
                begin
                    state_next = ST_DONE;
                end
                else if (status.ff_hit)
                begin
                    act = ACT_FF_SKIP;
                end
                else if (status.end_in_word)
                begin
                    act        = ACT_FF_TAKE;
                    state_next = ST_MK_RD;
                end
                else if (status.last_word)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    act        = ACT_FF_NEXT;
                    state_next = ST_FF_RD;
                end
            end
            ST_MK_RD:
            begin
                act        = ACT_READ;
                state_next = ST_MK_WR;
            end
            ST_MK_WR:
            begin
                act        = ACT_MARK;
                state_next = status.end_in_word ? ST_DONE : ST_MK_RD;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    act        = ACT_DELIVER;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bpra_dp.sv =====
// Datapath of the page range allocator: bitmap RAM, search window logic,
// pointer, used count and the result register. Depends on bpra_pkg and bpra_ram.
module bpra_dp
    import bpra_pkg::*;
#(
    parameter int PAGES = PAGES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  act_t                  act,
    output bpra_status_t          status,
    input  logic [COUNT_IN_W-1:0] req_pages,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  granted,
    output logic [START_W-1:0]    start_index,
    output logic [USED_W-1:0]     pages_in_use
);

    localparam int WORDS = (PAGES + WORD_W - 1) / WORD_W;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int AW    = $clog2(PAGES);
    localparam int XW    = $clog2(PAGES + WORDS * WORD_W) + 1;
    localparam int CW    = $clog2(PAGES + 1);
    localparam int TAIL  = PAGES - (WORDS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - TAIL);
    localparam logic [WA-1:0]     LAST_WORD = WA'(WORDS - 1);
    localparam logic [XW-1:0]     PAGES_X   = XW'(PAGES);

    // Control state, cleared at reset.
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    used_reg, used_next;
    logic [WORDS-1:0] word_valid_reg, word_valid_next;
    logic             out_valid_reg, out_valid_next;

    // Working and result payload.
    logic [XW-1:0]      need_reg, need_next;
    logic [XW-1:0]      cand_reg, cand_next;
    logic [WA-1:0]      word_reg, word_next;
    logic               wrap_reg, wrap_next;
    logic               grant_reg, grant_next;
    logic [XW-1:0]      start_reg, start_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               out_granted_reg, out_granted_next;
    logic [START_W-1:0] out_start_reg, out_start_next;
    logic [USED_W-1:0]  out_used_reg, out_used_next;

    // Window and search signals.
    logic [WORD_W-1:0]  ram_q;
    logic [WORD_W-1:0]  cur_word;
    logic [WORD_W-1:0]  range_mask;
    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  hi_mask;
    logic [WORD_W-1:0]  win_mask;
    logic [WORD_W-1:0]  used_win;
    logic [WORD_W-1:0]  free_nf;
    logic [WORD_LG-1:0] nf_bit;
    logic [WORD_LG-1:0] hi_bit;
    logic [XW-1:0]      word_base;
    logic [XW-1:0]      word_end;
    logic [XW-1:0]      cand_end;
    logic [XW-1:0]      rel_lo;
    logic [XW-1:0]      rel_hi;
    logic [XW-1:0]      nf_pos;
    logic [XW-1:0]      nf_after;
    logic [XW-1:0]      skip_pos;
    logic               ram_wr_en;
    logic [WORD_W-1:0]  ram_wr_data;
    req_kind_t          kind;

    // Bitmap storage, one word per entry.
    bpra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS),
        .ADDR_W(WA)
    ) u_map (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(word_reg),
        .wr_data(ram_wr_data),
        .rd_en  (act == ACT_READ),
        .rd_addr(word_reg),
        .rd_data(ram_q)
    );

    // A word never written since reset reads as all free.
    assign cur_word   = rd_valid_reg ? ram_q : '0;
    assign range_mask = (word_reg == LAST_WORD) ? TAIL_MASK : '1;
    assign word_base  = XW'({word_reg, {WORD_LG{1'b0}}});
    assign word_end   = word_base + XW'(WORD_W);
    assign cand_end   = cand_reg + need_reg;
    assign rel_lo     = cand_reg - word_base;
    assign rel_hi     = cand_end - word_base;

    // Window of slots from the candidate up to the end of the run, within this word.
    always_comb
    begin
        priority if (cand_reg <= word_base)
        begin
            lo_mask = '1;
        end
        else if (cand_reg >= word_end)
        begin
            lo_mask = '0;
        end
        else
        begin
            lo_mask = '1 << rel_lo[WORD_LG-1:0];
        end

        priority if (cand_end >= word_end)
        begin
            hi_mask = '1;
        end
        else if (cand_end <= word_base)
        begin
            hi_mask = '0;
        end
        else
        begin
            hi_mask = ~('1 << rel_hi[WORD_LG-1:0]);
        end
    end

    assign win_mask = lo_mask & hi_mask;
    assign used_win = (cur_word | ~range_mask) & win_mask;
    assign free_nf  = ~cur_word & range_mask & lo_mask;
    assign nf_bit   = lowest_set(free_nf);
    assign hi_bit   = highest_set(used_win);
    assign nf_pos   = word_base + XW'(nf_bit);
    assign nf_after = nf_pos + XW'(1);
    assign skip_pos = word_base + XW'(hi_bit) + XW'(1);

    // Request classification straight from the input port.
    always_comb
    begin
        priority if (req_pages == '0 || 32'(req_pages) > 32'(PAGES))
        begin
            kind = REQ_BAD;
        end
        else if (req_pages == COUNT_IN_W'(1))
        begin
            kind = REQ_SINGLE;
        end
        else
        begin
            kind = REQ_RUN;
        end
    end

    // Status towards the controller.
    always_comb
    begin
        status.kind        = kind;
        status.last_word   = (word_reg == LAST_WORD);
        status.nf_found    = |free_nf;
        status.nf_wrapped  = wrap_reg;
        status.ff_over     = (cand_end > PAGES_X);
        status.ff_hit      = |used_win;
        status.end_in_word = (cand_end <= word_end);
        status.out_free    = !out_valid_reg || !out_stall;
    end

    // Bitmap write: a single slot for next-fit, the run window when marking.
    always_comb
    begin
        ram_wr_en   = (act == ACT_NF_TAKE) || (act == ACT_MARK);
        ram_wr_data = (act == ACT_MARK) ? (cur_word | win_mask)
                                        : (cur_word | (WORD_W'(1) << nf_bit));
    end

    // Next values for each action.
    always_comb
    begin
        ptr_next         = ptr_reg;
        used_next        = used_reg;
        word_valid_next  = word_valid_reg;
        out_valid_next   = out_valid_reg && out_stall;
        need_next        = need_reg;
        cand_next        = cand_reg;
        word_next        = word_reg;
        wrap_next        = wrap_reg;
        grant_next       = grant_reg;
        start_next       = start_reg;
        rd_valid_next    = rd_valid_reg;
        out_granted_next = out_granted_reg;
        out_start_next   = out_start_reg;
        out_used_next    = out_used_reg;
        unique case (act)
            ACT_START:
            begin
                need_next  = XW'(req_pages);
                wrap_next  = 1'b0;
                grant_next = 1'b0;
                start_next = '0;
                if (kind == REQ_SINGLE)
                begin
                    cand_next = XW'(ptr_reg);
                    word_next = WA'(ptr_reg >> WORD_LG);
                end
                else
                begin
                    cand_next = '0;
                    word_next = '0;
                end
            end
            ACT_READ:
            begin
                rd_valid_next = word_valid_reg[word_reg];
            end
            ACT_NF_TAKE:
            begin
                grant_next                = 1'b1;
                start_next                = nf_pos;
                ptr_next                  = (nf_after == PAGES_X) ? '0 : AW'(nf_after);
                used_next                 = used_reg + CW'(1);
                word_valid_next[word_reg] = 1'b1;
            end
            ACT_NF_NEXT:
            begin
                word_next = word_reg + WA'(1);
                cand_next = word_end;
            end
            ACT_NF_WRAP:
            begin
                wrap_next = 1'b1;
                word_next = '0;
                cand_next = '0;
            end
            ACT_FF_SKIP:
            begin
                cand_next = skip_pos;
            end
            ACT_FF_NEXT:
            begin
                word_next = word_reg + WA'(1);
            end
            ACT_FF_TAKE:
            begin
                grant_next = 1'b1;
                start_next = cand_reg;
                used_next  = used_reg + CW'(need_reg);
                word_next  = WA'(cand_reg >> WORD_LG);
            end
            ACT_MARK:
            begin
                word_valid_next[word_reg] = 1'b1;
                word_next                 = word_reg + WA'(1);
            end
            ACT_DELIVER:
            begin
                out_valid_next   = 1'b1;
                out_granted_next = grant_reg;
                out_start_next   = START_W'(start_reg);
                out_used_next    = USED_W'(used_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            used_reg       <= '0;
            word_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg        <= ptr_next;
            used_reg       <= used_next;
            word_valid_reg <= word_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        need_reg        <= need_next;
        cand_reg        <= cand_next;
        word_reg        <= word_next;
        wrap_reg        <= wrap_next;
        grant_reg       <= grant_next;
        start_reg       <= start_next;
        rd_valid_reg    <= rd_valid_next;
        out_granted_reg <= out_granted_next;
        out_start_reg   <= out_start_next;
        out_used_reg    <= out_used_next;
    end

    assign out_valid    = out_valid_reg;
    assign granted      = out_granted_reg;
    assign start_index  = out_start_reg;
    assign pages_in_use = out_used_reg;

endmodule

// ===== tb/bitmap_page_range_allocator_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap page range allocator: a directed table, then
// random requests, each result checked against a bit-accurate allocation predictor or
// a hand-written result. Depends on bpra_pkg and bitmap_page_range_allocator_top.
module bitmap_page_range_allocator_top_tb
    import bpra_pkg::*;
();

    localparam int PAGES         = PAGES_DEFAULT;
    localparam int COUNT_MAX     = (1 << COUNT_IN_W) - 1;
    localparam int DIRECTED_ROWS = 15;
    localparam int RANDOM_ITEMS  = 800;
    localparam int DRAIN_CYCLES  = 100;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_REPORTS   = 10;

    // One result transfer as the block reports it.
    typedef struct packed {
        logic               granted;
        logic [START_W-1:0] start_index;
        logic [USED_W-1:0]  pages_in_use;
    } alloc_result_t;

    // One row of the directed table; fixed rows carry a hand-written result.
    typedef struct packed {
        logic [COUNT_IN_W-1:0] count;
        bit                    fixed;
        alloc_result_t         res;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [COUNT_IN_W-1:0] req_pages;
    logic                  out_valid;
    logic                  out_stall;
    logic                  granted;
    logic [START_W-1:0]    start_index;
    logic [USED_W-1:0]     pages_in_use;

    // Predictor state: the slot map, the next-fit rover and the used total.
    bit [PAGES-1:0] slot_taken;
    int             rover_ptr;
    int             taken_total;

    alloc_result_t  pending_grants[$];
    directed_row_t  directed_table[DIRECTED_ROWS];
    int             mismatch_count;
    int             results_seen;

    bitmap_page_range_allocator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_pages    (req_pages),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted      (granted),
        .start_index  (start_index),
        .pages_in_use (pages_in_use)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Allocates in the predictor: next-fit for a single page, first-fit for a run.
    function automatic alloc_result_t predict_alloc(input logic [COUNT_IN_W-1:0] cnt);
        alloc_result_t res;
        int            idx;
        int            k;
        int            run;
        int            first;
        bit            found;
        res   = '0;
        found = 1'b0;
        first = 0;
        if (cnt == 1)
        begin
            idx = rover_ptr;
            for (k = 0; k < PAGES && !found; k++)
            begin
                if (!slot_taken[idx])
                begin
                    slot_taken[idx] = 1'b1;
                    taken_total++;
                    rover_ptr = (idx + 1) % PAGES;
                    first     = idx;
                    found     = 1'b1;
                end
                else
                    idx = (idx + 1) % PAGES;
            end
        end
        else if (cnt >= 2 && cnt <= PAGES)
        begin
            run = 0;
            for (idx = 0; idx < PAGES && !found; idx++)
            begin
                if (slot_taken[idx])
                    run = 0;
                else
                begin
                    run++;
                    if (run == cnt)
                    begin
                        first = idx + 1 - int'(cnt);
                        for (k = first; k <= idx; k++)
                            slot_taken[k] = 1'b1;
                        taken_total += int'(cnt);
                        found = 1'b1;
                    end
                end
            end
        end
        res.granted      = found;
        res.start_index  = found ? START_W'(first) : '0;
        res.pages_in_use = USED_W'(taken_total);
        return res;
    endfunction

    // Length of the longest stretch of free slots in the predictor's map.
    function automatic int longest_free_run();
        int best;
        int run;
        int i;
        best = 0;
        run  = 0;
        for (i = 0; i < PAGES; i++)
        begin
            if (slot_taken[i])
                run = 0;
            else
            begin
                run++;
                if (run > best)
                    best = run;
            end
        end
        return best;
    endfunction

    // Random page count: small requests that keep the map fragmenting,
    // with exact fits, bad counts and requests too long for any free run.
    function automatic logic [COUNT_IN_W-1:0] pick_count();
        int sel;
        int longest;
        sel     = $urandom_range(99, 0);
        longest = longest_free_run();
        if (sel < 30)
            return COUNT_IN_W'(1);
        else if (sel < 42)
            return COUNT_IN_W'($urandom_range(3, 2));
        else if (sel < 46)
            return COUNT_IN_W'($urandom_range(12, 4));
        else if (sel < 47)
            return COUNT_IN_W'($urandom_range(48, 13));
        else if (sel < 50)
            return (longest >= 2 && longest <= 32) ? COUNT_IN_W'(longest) : COUNT_IN_W'(2);
        else if (sel < 58)
            return '0;
        else if (sel < 73 || longest >= PAGES)
            return COUNT_IN_W'($urandom_range(COUNT_MAX, PAGES + 1));
        else
            return COUNT_IN_W'($urandom_range(PAGES, longest + 1));
    endfunction

    // Counts a mismatch and reports the first few in full.
    task automatic note_mismatch(input string what, input alloc_result_t want,
                                 input alloc_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s: expected granted=%0d start_index=%0d pages_in_use=%0d,",
                     $time, what, want.granted, want.start_index, want.pages_in_use,
                     " got granted=%0d start_index=%0d pages_in_use=%0d",
                     got.granted, got.start_index, got.pages_in_use);
    endtask

    // Offers one request transfer, starting and ending at a falling edge, and
    // queues its expected result once the block has taken it.
    task automatic offer_request(input logic [COUNT_IN_W-1:0] cnt, input bit quiet,
                                 input bit fixed, input alloc_result_t fixed_res);
        alloc_result_t predicted;
        while (!quiet && $urandom_range(99, 0) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_pages <= cnt;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_alloc(cnt);
        pending_grants.push_back(fixed ? fixed_res : predicted);
        @(negedge clk);
    endtask

    function automatic directed_row_t dir_row(input int cnt, input bit fixed,
                                              input bit g, input int s, input int u);
        directed_row_t row;
        row.count            = COUNT_IN_W'(cnt);
        row.fixed            = fixed;
        row.res.granted      = g;
        row.res.start_index  = START_W'(s);
        row.res.pages_in_use = USED_W'(u);
        return row;
    endfunction

    // Result side: checks every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_grants.size() == 0)
                note_mismatch("result with nothing outstanding", '0,
                              {granted, start_index, pages_in_use});
            else if (granted !== pending_grants[0].granted
                     || start_index !== pending_grants[0].start_index
                     || pages_in_use !== pending_grants[0].pages_in_use)
                note_mismatch("result mismatch", pending_grants.pop_front(),
                              {granted, start_index, pages_in_use});
            else
                void'(pending_grants.pop_front());
        end
    end

    // Result side stall: random, one long hold-off to back the block up, and a
    // quiet window where every result is taken at once.
    initial
    begin : result_stall
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_once && results_seen >= 120)
            begin
                held_once = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (results_seen >= 315 && results_seen < 465)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99, 0) < 35);
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Request side: reset, the directed table, random requests, then drain.
    initial
    begin : request_stream
        int i;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_pages      = '0;
        slot_taken     = '0;
        rover_ptr      = 0;
        taken_total    = 0;
        mismatch_count = 0;
        results_seen   = 0;

        // Bad counts, the first single page, no room for a full map, a run
        // next to a used slot, then singles, runs across word boundaries and more bad counts.
        directed_table[0]  = dir_row(0,         1'b1, 1'b0, 0, 0);
        directed_table[1]  = dir_row(COUNT_MAX, 1'b1, 1'b0, 0, 0);
        directed_table[2]  = dir_row(PAGES + 1, 1'b1, 1'b0, 0, 0);
        directed_table[3]  = dir_row(1,         1'b1, 1'b1, 0, 1);
        directed_table[4]  = dir_row(PAGES,     1'b1, 1'b0, 0, 1);
        directed_table[5]  = dir_row(2,         1'b1, 1'b1, 1, 3);
        directed_table[6]  = dir_row(1,         1'b0, 1'b0, 0, 0);
        directed_table[7]  = dir_row(1,         1'b0, 1'b0, 0, 0);
        directed_table[8]  = dir_row(29,        1'b0, 1'b0, 0, 0);
        directed_table[9]  = dir_row(32,        1'b0, 1'b0, 0, 0);
        directed_table[10] = dir_row(1,         1'b0, 1'b0, 0, 0);
        directed_table[11] = dir_row(3,         1'b0, 1'b0, 0, 0);
        directed_table[12] = dir_row(PAGES - 1, 1'b0, 1'b0, 0, 0);
        directed_table[13] = dir_row(0,         1'b0, 1'b0, 0, 0);
        directed_table[14] = dir_row('h2AA,     1'b0, 1'b0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            offer_request(directed_table[i].count, 1'b0, directed_table[i].fixed,
                          directed_table[i].res);

        // Random requests; a middle stretch is offered back to back.
        for (i = 0; i < RANDOM_ITEMS; i++)
            offer_request(pick_count(), (i >= 300 && i < 450), 1'b0, '0);
        in_valid <= 1'b0;

        // Wait for the last results, then watch for stray ones.
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatch_count += pending_grants.size();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
